FILE: hdl/mdss_pkg.sv
// Shared types and constants for the motor drive safety state machine.
// Used by mdss_step and by the top level; depends on nothing else.
package mdss_pkg;

  // Drive states, one-hot in the state register.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RUN    = 5'b00010,
    ST_LIMP   = 5'b00100,
    ST_SOFT   = 5'b01000,
    ST_LOCKED = 5'b10000
  } drive_state_t;

  // Drive state codes as they appear in a result item.
  localparam logic [2:0] CODE_IDLE   = 3'd0;
  localparam logic [2:0] CODE_RUN    = 3'd1;
  localparam logic [2:0] CODE_LIMP   = 3'd2;
  localparam logic [2:0] CODE_SOFT   = 3'd3;
  localparam logic [2:0] CODE_LOCKED = 3'd4;

  // Kill, safety and mode codes of an input item.
  localparam logic [1:0] KILL_NONE     = 2'd0;
  localparam logic [1:0] KILL_SOFT     = 2'd1;
  localparam logic [1:0] SAFETY_SAFE   = 2'd0;
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_FAULT    = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MOVING_PWM_LEVEL      = 3'd0;
  localparam logic [2:0] REG_RUNAWAY_HOLD_MS       = 3'd1;
  localparam logic [2:0] REG_CALM_INTERVAL_MS      = 3'd2;
  localparam logic [2:0] REG_SOFT_STOP_TIMEOUT_MS  = 3'd3;
  localparam logic [2:0] REG_STOP_CURRENT_LEVEL    = 3'd4;
  localparam logic [2:0] REG_LIMP_LIMIT            = 3'd5;
  localparam logic [2:0] REG_ZERO_BAND             = 3'd6;

  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 40;

  typedef struct packed {
    logic [14:0] moving_pwm_level;
    logic [15:0] runaway_hold_ms;
    logic [15:0] calm_interval_ms;
    logic [15:0] soft_stop_timeout_ms;
    logic [14:0] stop_current_level;
    logic [14:0] limp_limit;
    logic [14:0] zero_band;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic [1:0]         kill_level;
    logic               system_active;
    logic [1:0]         safety_level;
    logic [1:0]         system_mode;
    logic signed [15:0] target_left_in;
    logic signed [15:0] target_right_in;
    logic signed [15:0] pwm_left;
    logic signed [15:0] pwm_right;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         drive_state_out;
    logic signed [15:0] target_left_out;
    logic signed [15:0] target_right_out;
    logic               safe_drive_pulse;
    logic               loop_reset_pulse;
    logic               runaway_fault;
    logic               watchdog_fault;
  } result_t;

  typedef struct packed {
    drive_state_t drive_state;
    drive_state_t previous_state;
    logic [31:0]  runaway_stamp;
    logic         runaway_armed;
    logic [31:0]  limp_calm_stamp;
    logic         limp_calm_armed;
    logic [31:0]  soft_stop_stamp;
    logic         soft_stop_armed;
  } ctrl_state_t;

endpackage

FILE: hdl/mdss_step.sv
// One control tick of the drive safety state machine, purely combinational.
// Depends on mdss_pkg for the item, result, state and configuration types.
module mdss_step (
  input  mdss_pkg::in_item_t    item,
  input  mdss_pkg::cfg_t        cfg,
  input  mdss_pkg::ctrl_state_t cur,
  output mdss_pkg::ctrl_state_t nxt,
  output mdss_pkg::result_t     res
);

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    mag16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] clamp16(input logic signed [15:0] v,
                                                  input logic [14:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] l17;
    logic signed [16:0] n17;
    v17 = {v[15], v};
    l17 = {2'b00, lim};
    n17 = -l17;
    if (v17 > l17) begin
      clamp16 = l17[15:0];
    end else if (v17 < n17) begin
      clamp16 = n17[15:0];
    end else begin
      clamp16 = v;
    end
  endfunction

  function automatic logic [2:0] encode(input mdss_pkg::drive_state_t s);
    case (s)
      mdss_pkg::ST_IDLE:   encode = mdss_pkg::CODE_IDLE;
      mdss_pkg::ST_RUN:    encode = mdss_pkg::CODE_RUN;
      mdss_pkg::ST_LIMP:   encode = mdss_pkg::CODE_LIMP;
      mdss_pkg::ST_SOFT:   encode = mdss_pkg::CODE_SOFT;
      default:             encode = mdss_pkg::CODE_LOCKED;
    endcase
  endfunction

  logic                   hard_kill;
  logic                   soft_kill;
  logic                   emergency;
  logic                   safe_ok;
  logic                   cmd_zero;
  logic                   moving;
  logic                   stopped;
  logic [31:0]            runaway_start;
  logic [31:0]            runaway_age;
  logic [31:0]            calm_age;
  logic [31:0]            soft_start;
  logic [31:0]            soft_age;
  mdss_pkg::drive_state_t st;
  logic signed [15:0]     tl;
  logic signed [15:0]     tr;

  always_comb begin
    hard_kill = item.kill_level[1];
    soft_kill = (item.kill_level == mdss_pkg::KILL_SOFT);
    emergency = item.safety_level[1];
    safe_ok   = (item.safety_level == mdss_pkg::SAFETY_SAFE);
    cmd_zero  = (mag16(item.target_left_in)  <= {1'b0, cfg.zero_band}) &&
                (mag16(item.target_right_in) <= {1'b0, cfg.zero_band});
    moving    = (mag16(item.pwm_left)  > {1'b0, cfg.moving_pwm_level}) ||
                (mag16(item.pwm_right) > {1'b0, cfg.moving_pwm_level});
    stopped   = (mag16(item.pwm_left)  < {1'b0, cfg.stop_current_level}) &&
                (mag16(item.pwm_right) < {1'b0, cfg.stop_current_level});
    runaway_start = cur.runaway_armed ? cur.runaway_stamp : item.time_ms;
    runaway_age   = item.time_ms - runaway_start;
    calm_age      = item.time_ms - cur.limp_calm_stamp;
    soft_start    = cur.soft_stop_armed ? cur.soft_stop_stamp : item.time_ms;
    soft_age      = item.time_ms - soft_start;

    nxt = cur;
    st  = cur.drive_state;
    tl  = item.target_left_in;
    tr  = item.target_right_in;
    res = '0;

    if (hard_kill) begin
      // Hard kill locks at once and leaves the timers and bookkeeping alone.
      nxt.drive_state      = mdss_pkg::ST_LOCKED;
      res.drive_state_out  = mdss_pkg::CODE_LOCKED;
      res.safe_drive_pulse = 1'b1;
    end else begin
      if (soft_kill && st != mdss_pkg::ST_SOFT && st != mdss_pkg::ST_LOCKED) begin
        st = mdss_pkg::ST_SOFT;
      end

      // Runaway watch: commands near zero while a motor still turns.
      if (cmd_zero && moving) begin
        nxt.runaway_stamp = runaway_start;
        nxt.runaway_armed = 1'b1;
        res.runaway_fault = (runaway_age > {16'd0, cfg.runaway_hold_ms});
      end else begin
        nxt.runaway_armed = 1'b0;
      end

      case (st)
        mdss_pkg::ST_IDLE: begin
          tl = '0;
          tr = '0;
          nxt.limp_calm_armed  = 1'b0;
          nxt.soft_stop_armed  = 1'b0;
          res.loop_reset_pulse = 1'b1;
          if (item.system_active && item.kill_level == mdss_pkg::KILL_NONE) begin
            st = mdss_pkg::ST_RUN;
          end
        end
        mdss_pkg::ST_RUN: begin
          if (item.system_mode[1]) begin
            st = mdss_pkg::ST_LIMP;
            nxt.limp_calm_armed = 1'b0;
          end
        end
        mdss_pkg::ST_LIMP: begin
          tl = clamp16(item.target_left_in,  cfg.limp_limit);
          tr = clamp16(item.target_right_in, cfg.limp_limit);
          if (emergency) begin
            st = mdss_pkg::ST_SOFT;
          end else if (item.system_mode == mdss_pkg::MODE_NORMAL && safe_ok) begin
            if (!cur.limp_calm_armed) begin
              nxt.limp_calm_stamp = item.time_ms;
              nxt.limp_calm_armed = 1'b1;
            end else if (calm_age >= {16'd0, cfg.calm_interval_ms}) begin
              st = mdss_pkg::ST_RUN;
              nxt.limp_calm_armed = 1'b0;
            end
          end else begin
            nxt.limp_calm_armed = 1'b0;
          end
        end
        mdss_pkg::ST_SOFT: begin
          tl = '0;
          tr = '0;
          if (!cur.soft_stop_armed) begin
            nxt.soft_stop_stamp  = item.time_ms;
            nxt.soft_stop_armed  = 1'b1;
            res.loop_reset_pulse = 1'b1;
          end
          if (stopped || soft_age >= {16'd0, cfg.soft_stop_timeout_ms}) begin
            res.safe_drive_pulse = 1'b1;
            st = mdss_pkg::ST_LOCKED;
          end
        end
        mdss_pkg::ST_LOCKED: begin
          tl = '0;
          tr = '0;
          res.safe_drive_pulse = 1'b1;
          if (item.kill_level == mdss_pkg::KILL_NONE && item.system_active && safe_ok &&
              item.system_mode != mdss_pkg::MODE_FAULT) begin
            st = mdss_pkg::ST_IDLE;
          end
        end
        default: begin
          // Corrupt state register: flag it and fall back to locked.
          res.watchdog_fault   = 1'b1;
          res.safe_drive_pulse = 1'b1;
          tl = '0;
          tr = '0;
          st = mdss_pkg::ST_LOCKED;
          nxt.limp_calm_armed = 1'b0;
          nxt.soft_stop_armed = 1'b0;
        end
      endcase

      // On any change of state, entering soft stop starts its timer.
      if (st != cur.previous_state) begin
        if (st == mdss_pkg::ST_SOFT) begin
          nxt.soft_stop_stamp = item.time_ms;
          nxt.soft_stop_armed = 1'b1;
        end
        nxt.previous_state = st;
      end

      nxt.drive_state      = st;
      res.drive_state_out  = encode(st);
      res.target_left_out  = tl;
      res.target_right_out = tr;
    end
  end

endmodule

FILE: hdl/motor_drive_safety_state_machine.sv
// Top level of the motor drive safety state machine: stream ports, input and
// result registers, configuration registers. Depends on mdss_pkg and mdss_step.
//
//  Channel   Direction  Handshake                      Payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  one control tick, 104-bit tdata
//  m_axis    out        m_axis_tvalid / m_axis_tready  one result, 40-bit tdata
//  cfg       in         cfg_we (no wait)               cfg_index, cfg_data
//
// An item is captured in the input register, and when it moves on one pass of
// mdss_step computes its result and the new drive state, both loaded at the same
// edge, so an item that follows at once already sees the updated state.
// The result waits in the result register until it is taken; one item per cycle
// is taken while the result side keeps up.
// A stall on the result side holds the result register and the input register;
// the input side stays ready while the input register is empty or will drain this cycle.
// Reset (rst, synchronous, active high) returns the state to idle, disarms all
// timers, restores register defaults and empties both stages.
module motor_drive_safety_state_machine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata from bit 0: time_ms[31:0], kill_level[33:32], system_active[34],
  // safety_level[36:35], system_mode[38:37], target_left_in[54:39],
  // target_right_in[70:55], pwm_left[86:71], pwm_right[102:87], unused [103]
  input  logic [mdss_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata from bit 0: drive_state_out[2:0], target_left_out[18:3],
  // target_right_out[34:19], safe_drive_pulse[35], loop_reset_pulse[36],
  // runaway_fault[37], watchdog_fault[38], zero [39]
  output logic [mdss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [mdss_pkg::CFG_DATA_W-1:0] cfg_data
);

  mdss_pkg::cfg_t        cfg;
  mdss_pkg::ctrl_state_t state;
  mdss_pkg::ctrl_state_t state_next;
  mdss_pkg::in_item_t    in_item;
  mdss_pkg::in_item_t    item;
  logic                  item_valid;
  mdss_pkg::result_t     result;
  mdss_pkg::result_t     result_next;
  logic                  result_valid;
  logic                  advance;
  logic                  in_accept;

  // Unpack the incoming tick, lowest field in the lowest bits.
  assign in_item.time_ms         = s_axis_tdata[31:0];
  assign in_item.kill_level      = s_axis_tdata[33:32];
  assign in_item.system_active   = s_axis_tdata[34];
  assign in_item.safety_level    = s_axis_tdata[36:35];
  assign in_item.system_mode     = s_axis_tdata[38:37];
  assign in_item.target_left_in  = s_axis_tdata[54:39];
  assign in_item.target_right_in = s_axis_tdata[70:55];
  assign in_item.pwm_left        = s_axis_tdata[86:71];
  assign in_item.pwm_right       = s_axis_tdata[102:87];

  // The held item moves on whenever the result register is empty or being read.
  assign advance       = item_valid && (!result_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mdss_step u_step (
    .item (item),
    .cfg  (cfg),
    .cur  (state),
    .nxt  (state_next),
    .res  (result_next)
  );

  // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.moving_pwm_level      <= 15'd120;
      cfg.runaway_hold_ms       <= 16'd200;
      cfg.calm_interval_ms      <= 16'd3000;
      cfg.soft_stop_timeout_ms  <= 16'd2000;
      cfg.stop_current_level    <= 15'd3;
      cfg.limp_limit            <= 15'd8192;
      cfg.zero_band             <= 15'd819;
    end else if (cfg_we) begin
      case (cfg_index)
        mdss_pkg::REG_MOVING_PWM_LEVEL:      cfg.moving_pwm_level      <= cfg_data[14:0];
        mdss_pkg::REG_RUNAWAY_HOLD_MS:       cfg.runaway_hold_ms       <= cfg_data;
        mdss_pkg::REG_CALM_INTERVAL_MS:      cfg.calm_interval_ms      <= cfg_data;
        mdss_pkg::REG_SOFT_STOP_TIMEOUT_MS:  cfg.soft_stop_timeout_ms  <= cfg_data;
        mdss_pkg::REG_STOP_CURRENT_LEVEL:    cfg.stop_current_level    <= cfg_data[14:0];
        mdss_pkg::REG_LIMP_LIMIT:            cfg.limp_limit            <= cfg_data[14:0];
        mdss_pkg::REG_ZERO_BAND:             cfg.zero_band             <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item <= in_item;
    end
  end

  // Drive state and timers change only when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.drive_state     <= mdss_pkg::ST_IDLE;
      state.previous_state  <= mdss_pkg::ST_IDLE;
      state.runaway_stamp   <= '0;
      state.runaway_armed   <= 1'b0;
      state.limp_calm_stamp <= '0;
      state.limp_calm_armed <= 1'b0;
      state.soft_stop_stamp <= '0;
      state.soft_stop_armed <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (m_axis_tready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_axis_tvalid = result_valid;
  assign m_axis_tdata  = {1'b0, result.watchdog_fault, result.runaway_fault,
                          result.loop_reset_pulse, result.safe_drive_pulse,
                          result.target_right_out, result.target_left_out,
                          result.drive_state_out};

  // A result that forces the outputs off never carries a nonzero target.
  a_safe_zero_targets: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.safe_drive_pulse |->
      result.target_left_out == '0 && result.target_right_out == '0)
    else $error("safe drive pulse with nonzero target");

  // A watchdog fault always reports the locked state.
  a_watchdog_locked: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && result.watchdog_fault |->
      result.drive_state_out == mdss_pkg::CODE_LOCKED)
    else $error("watchdog fault without locked state");

  // A hard kill locks the drive in the very next result.
  a_hard_kill_locks: assert property (@(posedge clk) disable iff (rst)
    advance && item.kill_level[1] |=>
      result.drive_state_out == mdss_pkg::CODE_LOCKED &&
      state.drive_state == mdss_pkg::ST_LOCKED)
    else $error("hard kill did not lock the drive");

  // A hard kill leaves the change bookkeeping untouched.
  a_hard_kill_keeps_prev: assert property (@(posedge clk) disable iff (rst)
    advance && item.kill_level[1] |=> $stable(state.previous_state))
    else $error("hard kill changed the previous state");

  // The state only moves when an item is processed.
  a_state_only_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state.drive_state))
    else $error("drive state changed without an item");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the motor drive safety state machine: stream stimulus,
// a tracker class that predicts every result item, and random flow control.
// Depends on mdss_pkg and the top level motor_drive_safety_state_machine.
module tb;

  // Codes the package leaves out but the stimulus needs by name.
  localparam logic [1:0] KILL_HARD         = 2'd2;
  localparam logic [1:0] KILL_THREE        = 2'd3;
  localparam logic [1:0] SAFETY_WARNING    = 2'd1;
  localparam logic [1:0] SAFETY_EMERGENCY  = 2'd2;
  localparam logic [1:0] SAFETY_THREE      = 2'd3;
  localparam logic [1:0] MODE_DEGRADED_ONE = 2'd1;
  localparam logic [1:0] MODE_DEGRADED_TWO = 2'd2;

  // Flavors of random traffic; each one steers the drive toward one part of its behavior.
  typedef enum int {
    MOOD_CALM,
    MOOD_DEGRADED,
    MOOD_RUNAWAY,
    MOOD_STOPPING,
    MOOD_NOISE
  } mood_t;

  // Tracks the drive state machine tick by tick and holds the results still to come.
  class safety_checker_t;
    mdss_pkg::cfg_t    cfg;
    logic [2:0]        drive_code;
    logic [2:0]        last_code;
    logic [31:0]       runaway_since;
    bit                runaway_on;
    logic [31:0]       calm_since;
    bit                calm_on;
    logic [31:0]       stop_since;
    bit                stop_on;
    mdss_pkg::result_t awaited_results[$];
    int                mismatches;

    function new();
      cfg.moving_pwm_level      = 15'd120;
      cfg.runaway_hold_ms       = 16'd200;
      cfg.calm_interval_ms      = 16'd3000;
      cfg.soft_stop_timeout_ms  = 16'd2000;
      cfg.stop_current_level    = 15'd3;
      cfg.limp_limit            = 15'd8192;
      cfg.zero_band             = 15'd819;
      drive_code    = mdss_pkg::CODE_IDLE;
      last_code     = mdss_pkg::CODE_IDLE;
      runaway_since = '0;
      runaway_on    = 1'b0;
      calm_since    = '0;
      calm_on       = 1'b0;
      stop_since    = '0;
      stop_on       = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [15:0] value);
      case (index)
        mdss_pkg::REG_MOVING_PWM_LEVEL:     cfg.moving_pwm_level      = value[14:0];
        mdss_pkg::REG_RUNAWAY_HOLD_MS:      cfg.runaway_hold_ms       = value;
        mdss_pkg::REG_CALM_INTERVAL_MS:     cfg.calm_interval_ms      = value;
        mdss_pkg::REG_SOFT_STOP_TIMEOUT_MS: cfg.soft_stop_timeout_ms  = value;
        mdss_pkg::REG_STOP_CURRENT_LEVEL:   cfg.stop_current_level    = value[14:0];
        mdss_pkg::REG_LIMP_LIMIT:           cfg.limp_limit            = value[14:0];
        mdss_pkg::REG_ZERO_BAND:            cfg.zero_band             = value[14:0];
        default: ;
      endcase
    endfunction

    function int mag(int v);
      return (v < 0) ? -v : v;
    endfunction

    function int clamp_to(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    // One control tick: updates the tracked state and returns the result item.
    function mdss_pkg::result_t next_drive_result(mdss_pkg::in_item_t x);
      mdss_pkg::result_t r;
      int                tl;
      int                tr;
      int                pl;
      int                pr;
      logic [31:0]       now;
      bit                cmd_zero;
      bit                moving;
      bit                emergency;
      bit                safe_ok;
      r         = '0;
      now       = x.time_ms;
      tl        = int'(x.target_left_in);
      tr        = int'(x.target_right_in);
      pl        = int'(x.pwm_left);
      pr        = int'(x.pwm_right);
      emergency = x.safety_level >= SAFETY_EMERGENCY;
      safe_ok   = x.safety_level == mdss_pkg::SAFETY_SAFE;

      // A hard kill bypasses everything, including the change bookkeeping.
      if (x.kill_level >= KILL_HARD) begin
        drive_code = mdss_pkg::CODE_LOCKED;
        r.drive_state_out  = mdss_pkg::CODE_LOCKED;
        r.safe_drive_pulse = 1'b1;
        return r;
      end
      if (x.kill_level == mdss_pkg::KILL_SOFT && drive_code != mdss_pkg::CODE_SOFT &&
          drive_code != mdss_pkg::CODE_LOCKED)
        drive_code = mdss_pkg::CODE_SOFT;

      cmd_zero = mag(tl) <= int'(cfg.zero_band) && mag(tr) <= int'(cfg.zero_band);
      moving   = mag(pl) > int'(cfg.moving_pwm_level) || mag(pr) > int'(cfg.moving_pwm_level);
      if (cmd_zero && moving) begin
        if (!runaway_on) begin
          runaway_since = now;
          runaway_on    = 1'b1;
        end
        if (now - runaway_since > {16'd0, cfg.runaway_hold_ms}) r.runaway_fault = 1'b1;
      end else begin
        runaway_on = 1'b0;
      end

      case (drive_code)
        mdss_pkg::CODE_IDLE: begin
          tl = 0;
          tr = 0;
          calm_on = 1'b0;
          stop_on = 1'b0;
          r.loop_reset_pulse = 1'b1;
          if (x.system_active && x.kill_level == mdss_pkg::KILL_NONE)
            drive_code = mdss_pkg::CODE_RUN;
        end
        mdss_pkg::CODE_RUN: begin
          if (x.system_mode == MODE_DEGRADED_TWO || x.system_mode == mdss_pkg::MODE_FAULT) begin
            drive_code = mdss_pkg::CODE_LIMP;
            calm_on    = 1'b0;
          end
        end
        mdss_pkg::CODE_LIMP: begin
          tl = clamp_to(tl, int'(cfg.limp_limit));
          tr = clamp_to(tr, int'(cfg.limp_limit));
          if (emergency) begin
            drive_code = mdss_pkg::CODE_SOFT;
          end else if (x.system_mode == mdss_pkg::MODE_NORMAL && safe_ok) begin
            if (!calm_on) begin
              calm_since = now;
              calm_on    = 1'b1;
            end else if (now - calm_since >= {16'd0, cfg.calm_interval_ms}) begin
              drive_code = mdss_pkg::CODE_RUN;
              calm_on    = 1'b0;
            end
          end else begin
            calm_on = 1'b0;
          end
        end
        mdss_pkg::CODE_SOFT: begin
          tl = 0;
          tr = 0;
          if (!stop_on) begin
            stop_since = now;
            stop_on    = 1'b1;
            r.loop_reset_pulse = 1'b1;
          end
          if ((mag(pl) < int'(cfg.stop_current_level) &&
               mag(pr) < int'(cfg.stop_current_level)) ||
              now - stop_since >= {16'd0, cfg.soft_stop_timeout_ms}) begin
            r.safe_drive_pulse = 1'b1;
            drive_code = mdss_pkg::CODE_LOCKED;
          end
        end
        mdss_pkg::CODE_LOCKED: begin
          tl = 0;
          tr = 0;
          r.safe_drive_pulse = 1'b1;
          if (x.kill_level == mdss_pkg::KILL_NONE && x.system_active && safe_ok &&
              x.system_mode != mdss_pkg::MODE_FAULT)
            drive_code = mdss_pkg::CODE_IDLE;
        end
        default: begin
          r.watchdog_fault   = 1'b1;
          r.safe_drive_pulse = 1'b1;
          tl = 0;
          tr = 0;
          drive_code = mdss_pkg::CODE_LOCKED;
          calm_on = 1'b0;
          stop_on = 1'b0;
        end
      endcase

      if (drive_code != last_code) begin
        if (drive_code == mdss_pkg::CODE_SOFT) begin
          stop_since = now;
          stop_on    = 1'b1;
        end
        last_code = drive_code;
      end

      r.drive_state_out  = drive_code;
      r.target_left_out  = tl[15:0];
      r.target_right_out = tr[15:0];
      return r;
    endfunction

    function void note_tick(mdss_pkg::in_item_t x);
      awaited_results.push_back(next_drive_result(x));
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(mdss_pkg::result_t got);
      mdss_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result item with nothing expected, expected none actual %h",
                 $time, got);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("drive_state_out", int'(want.drive_state_out),
                    int'(got.drive_state_out));
      compare_field("target_left_out", int'(want.target_left_out),
                    int'(got.target_left_out));
      compare_field("target_right_out", int'(want.target_right_out),
                    int'(got.target_right_out));
      compare_field("safe_drive_pulse", int'(want.safe_drive_pulse),
                    int'(got.safe_drive_pulse));
      compare_field("loop_reset_pulse", int'(want.loop_reset_pulse),
                    int'(got.loop_reset_pulse));
      compare_field("runaway_fault", int'(want.runaway_fault), int'(got.runaway_fault));
      compare_field("watchdog_fault", int'(want.watchdog_fault), int'(got.watchdog_fault));
    endfunction
  endclass

  logic                            clk           = 1'b0;
  logic                            rst           = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [mdss_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [mdss_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_we        = 1'b0;
  logic [2:0]                      cfg_index     = '0;
  logic [mdss_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

  safety_checker_t book = new();

  // Flow control knobs, in percent per cycle, set by the main sequence per phase.
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  // The main sequence bumps hold_requests; the receiver serves each one with a long stall.
  int                hold_requests  = 0;
  int                holds_served   = 0;
  int                hold_left      = 0;
  logic [31:0]       clock_ms       = 32'hFFFF_FF00;
  mood_t             mood           = MOOD_CALM;
  int                mood_left      = 0;
  mdss_pkg::result_t seen;

  motor_drive_safety_state_machine dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: checks each accepted result item, then picks tready for the next cycle.
  // A pending hold request turns into a long run of cycles with tready low, which lets
  // both stages of the block fill and pushes back on the input side.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.drive_state_out  = m_axis_tdata[2:0];
      seen.target_left_out  = m_axis_tdata[18:3];
      seen.target_right_out = m_axis_tdata[34:19];
      seen.safe_drive_pulse = m_axis_tdata[35];
      seen.loop_reset_pulse = m_axis_tdata[36];
      seen.runaway_fault    = m_axis_tdata[37];
      seen.watchdog_fault   = m_axis_tdata[38];
      book.check_result(seen);
    end
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offers one input item, with random idle cycles ahead of it, and waits until it is taken.
  // tvalid is only ever raised after the gap, so it never drops and rises in one step.
  task automatic send_tick(mdss_pkg::in_item_t x);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, x.pwm_right, x.pwm_left, x.target_right_in, x.target_left_in,
                      x.system_mode, x.safety_level, x.system_active, x.kill_level,
                      x.time_ms};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    book.note_tick(x);
  endtask

  // Directed tick: advances the millisecond clock and sends the item.
  task automatic drive(int delta, logic [1:0] kill, logic active, logic [1:0] safety,
                       logic [1:0] mode, int tl, int tr, int pl, int pr);
    mdss_pkg::in_item_t x;
    clock_ms = clock_ms + 32'(delta);
    x.time_ms         = clock_ms;
    x.kill_level      = kill;
    x.system_active   = active;
    x.safety_level    = safety;
    x.system_mode     = mode;
    x.target_left_in  = tl[15:0];
    x.target_right_in = tr[15:0];
    x.pwm_left        = pl[15:0];
    x.pwm_right       = pr[15:0];
    send_tick(x);
  endtask

  // Stops offering items and waits until every expected result item has come back.
  task automatic pause_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (book.awaited_results.size() != 0);
  endtask

  // Writes all seven registers on consecutive cycles; the block is idle meanwhile.
  task automatic load_config(logic [15:0] thr, logic [15:0] confirm, logic [15:0] recover,
                             logic [15:0] timeout, logic [15:0] stop_level,
                             logic [15:0] limp, logic [15:0] band);
    logic [15:0] vals [7];
    vals[mdss_pkg::REG_MOVING_PWM_LEVEL]     = thr;
    vals[mdss_pkg::REG_RUNAWAY_HOLD_MS]      = confirm;
    vals[mdss_pkg::REG_CALM_INTERVAL_MS]     = recover;
    vals[mdss_pkg::REG_SOFT_STOP_TIMEOUT_MS] = timeout;
    vals[mdss_pkg::REG_STOP_CURRENT_LEVEL]   = stop_level;
    vals[mdss_pkg::REG_LIMP_LIMIT]           = limp;
    vals[mdss_pkg::REG_ZERO_BAND]            = band;
    cfg_we <= 1'b1;
    for (int i = int'(mdss_pkg::REG_MOVING_PWM_LEVEL); i <= int'(mdss_pkg::REG_ZERO_BAND);
         i++) begin
      cfg_index <= i[2:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      book.set_reg(i[2:0], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // A value at, just past, or inside a band of the given half width.
  function automatic logic [15:0] near_band(int lim);
    case ($urandom_range(0, 4))
      0: return lim[15:0];
      1: return 16'(-lim);
      2: return 16'(lim + 1);
      3: return 16'(-lim - 1);
      default: return 16'(int'($urandom_range(0, 2 * lim)) - lim);
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 16'($urandom());
    if (roll < 70) return near_band(int'(book.cfg.limp_limit));
    if (roll < 85) return near_band(int'(book.cfg.zero_band));
    case ($urandom_range(0, 2))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'h0000;
    endcase
  endfunction

  // Builds one random tick. Most moods keep the kill and status inputs sane so the
  // drive gets through run, limp and soft stop; the noise mood throws anything at it.
  function automatic mdss_pkg::in_item_t make_tick(mood_t m, logic [31:0] stamp);
    mdss_pkg::in_item_t x;
    int roll;
    x.time_ms = stamp;
    roll = $urandom_range(0, 99);
    if (m == MOOD_NOISE) begin
      x.kill_level = 2'($urandom_range(0, 3));
    end else if (m == MOOD_STOPPING) begin
      x.kill_level = (roll < 25) ? mdss_pkg::KILL_SOFT :
                     (roll < 28) ? KILL_HARD : mdss_pkg::KILL_NONE;
    end else begin
      x.kill_level = (roll < 2) ? mdss_pkg::KILL_SOFT :
                     (roll < 4) ? KILL_HARD + roll[0] : mdss_pkg::KILL_NONE;
    end
    x.system_active = (m == MOOD_NOISE) ? 1'($urandom_range(0, 1)) :
                                          ($urandom_range(0, 99) < 93);
    case (m)
      MOOD_CALM: begin
        x.safety_level = ($urandom_range(0, 99) < 90) ? mdss_pkg::SAFETY_SAFE :
                                                        2'($urandom_range(0, 3));
        x.system_mode  = ($urandom_range(0, 99) < 85) ? mdss_pkg::MODE_NORMAL :
                                                        2'($urandom_range(0, 3));
      end
      MOOD_DEGRADED: begin
        x.safety_level = 2'($urandom_range(0, 3));
        x.system_mode  = ($urandom_range(0, 99) < 60) ?
                         2'($urandom_range(MODE_DEGRADED_TWO, mdss_pkg::MODE_FAULT)) :
                         2'($urandom_range(0, 3));
      end
      MOOD_NOISE: begin
        x.safety_level = 2'($urandom_range(0, 3));
        x.system_mode  = 2'($urandom_range(0, 3));
      end
      default: begin
        x.safety_level = ($urandom_range(0, 99) < 80) ? mdss_pkg::SAFETY_SAFE :
                                                        2'($urandom_range(0, 3));
        x.system_mode  = 2'($urandom_range(0, 3));
      end
    endcase
    if (m == MOOD_RUNAWAY) begin
      x.target_left_in  = near_band(int'(book.cfg.zero_band));
      x.target_right_in = near_band(int'(book.cfg.zero_band));
      x.pwm_left  = ($urandom_range(0, 99) < 60) ? 16'($urandom()) :
                    near_band(int'(book.cfg.moving_pwm_level));
      x.pwm_right = ($urandom_range(0, 99) < 60) ? 16'($urandom()) :
                    near_band(int'(book.cfg.moving_pwm_level));
    end else begin
      x.target_left_in  = pick_target();
      x.target_right_in = pick_target();
      if (m == MOOD_STOPPING) begin
        x.pwm_left  = ($urandom_range(0, 99) < 70) ?
                      near_band(int'(book.cfg.stop_current_level)) : 16'($urandom());
        x.pwm_right = ($urandom_range(0, 99) < 70) ?
                      near_band(int'(book.cfg.stop_current_level)) : 16'($urandom());
      end else begin
        x.pwm_left  = 16'($urandom());
        x.pwm_right = 16'($urandom());
      end
    end
    return x;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed walk with the reset settings. The clock starts just below the 32-bit
    // wrap, so the limp recovery below measures its interval across the wrap.
    drive(5, mdss_pkg::KILL_NONE, 1'b0, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          1000, -1000, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          32767, -32768, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, MODE_DEGRADED_ONE,
          32767, -32768, 500, -500);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, SAFETY_WARNING, MODE_DEGRADED_TWO,
          -32768, 32767, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          -32768, 32767, 0, 0);
    drive(3000, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          8193, -8193, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_FAULT,
          9000, -9000, 0, 0);
    // Safety code three counts as an emergency and sends limp into soft stop.
    drive(5, mdss_pkg::KILL_NONE, 1'b1, SAFETY_THREE, mdss_pkg::MODE_FAULT,
          9000, -9000, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 1000, 1000);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 2, -2);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_FAULT,
          0, 0, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 0, 0);
    // Runaway: targets inside the zero band while a motor still moves.
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          819, -819, 121, 0);
    drive(201, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          819, -819, 0, -121);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          820, 0, 0, -121);
    // Soft kill, then a soft stop that ends on its timeout.
    drive(5, mdss_pkg::KILL_SOFT, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          4000, 4000, 1000, 1000);
    drive(2000, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          4000, 4000, 1000, 1000);
    drive(5, KILL_HARD, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          4000, 4000, 1000, 1000);
    // Kill code three acts as a hard kill.
    drive(5, KILL_THREE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          4000, 4000, 1000, 1000);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          0, 0, 0, 0);
    // A hard kill straight from run keeps the old state in the change bookkeeping.
    drive(5, KILL_HARD, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          100, 100, 0, 0);
    drive(5, mdss_pkg::KILL_SOFT, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          100, 100, 0, 0);
    drive(5, mdss_pkg::KILL_NONE, 1'b1, mdss_pkg::SAFETY_SAFE, mdss_pkg::MODE_NORMAL,
          100, 100, 0, 0);

    // Random phases, each with its own register settings and flow control pattern.
    for (int phase = 0; phase < 6; phase++) begin
      pause_until_drained();
      case (phase)
        0: load_config(16'd100, 16'd150, 16'd400, 16'd300, 16'd50, 16'd8192, 16'd819);
        1: load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_config(16'd32767, 16'd65535, 16'd65535, 16'd65535, 16'd32767, 16'd32767,
                       16'd32767);
        3: load_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 800)),
                       16'($urandom_range(0, 1500)), 16'($urandom_range(0, 1500)),
                       16'($urandom_range(0, 500)), 16'($urandom_range(0, 32767)),
                       16'($urandom_range(0, 4000)));
        4: load_config(16'd500, 16'd60, 16'd200, 16'd100, 16'd1000, 16'd4096, 16'd2000);
        default: load_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                             16'($urandom_range(0, 32767)));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 16;
          recv_stall_pct = 16;
        end
      endcase
      for (int n = 0; n < 280; n++) begin
        if (mood_left == 0) begin
          mood      = mood_t'($urandom_range(MOOD_CALM, MOOD_NOISE));
          mood_left = $urandom_range(10, 30);
        end
        mood_left--;
        // Mostly short steps so the timers run out in reach, sometimes a jump anywhere.
        case ($urandom_range(0, 19))
          0: clock_ms = $urandom();
          1, 2, 3, 4, 5: clock_ms = clock_ms + $urandom_range(0, 700);
          default: clock_ms = clock_ms + $urandom_range(0, 50);
        endcase
        send_tick(make_tick(mood, clock_ms));
        if (phase == 0 && n == 100) hold_requests++;
        if (phase == 1 && n == 140) pause_until_drained();
      end
    end

    pause_until_drained();
    repeat (8) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog on the whole run, far beyond the slowest legal traffic.
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
